>>> src/lslp_pkg.sv
package lslp_pkg;

    localparam int SAMPLE_W = 32;
    // Tap weights are Q.20; |w| <= 4/3 for any window of 3 or more.
    localparam int FRAC_W   = 20;
    localparam int WEIGHT_W = 23;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W    = 64;

    typedef struct packed {
        logic mul_en;   // operand and weight valid this cycle
        logic first;    // first tap of an item: restart the sum
    } t_mac_ctl;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

endpackage

>>> src/lslp_cell.sv
module lslp_cell
    import lslp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic signed [SAMPLE_W-1:0] i_d,
    output logic signed [SAMPLE_W-1:0] o_q
);

    logic signed [SAMPLE_W-1:0] r_q;
    logic signed [SAMPLE_W-1:0] n_q;

    always_comb begin
        n_q = i_shift ? i_d : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

>>> src/lslp_mac.sv
module lslp_mac
    import lslp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctl                   i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_operand,
    input  logic signed [WEIGHT_W-1:0] i_weight,
    output logic signed [SAMPLE_W-1:0] o_result
);

    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) << (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic                     r_pfirst;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_pfirst <= 1'b0;
        end else begin
            r_pv     <= i_ctl.mul_en;
            r_pfirst <= i_ctl.first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_operand * i_weight;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (r_pv) begin
            n_acc = r_pfirst ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // round half up, then clamp to the 32-bit range
    always_comb begin
        rnd = r_acc + HALF;
        quo = rnd >>> FRAC_W;
        if (quo > SAT_HI) begin
            o_result = SAMPLE_W'(SAT_HI);
        end else if (quo < SAT_LO) begin
            o_result = SAMPLE_W'(SAT_LO);
        end else begin
            o_result = SAMPLE_W'(quo);
        end
    end

endmodule

>>> src/least_squares_line_predictor.sv
// One-step-ahead least-squares line predictor over a sliding window.
// Input channel: i_in_valid / o_in_stall carry one signed sample per item.
// Output channel: o_out_valid / i_out_stall carry one prediction per item.
// Each item is fitted together with the WINDOW-1 previous samples and the
// line is evaluated one step past the newest sample; the result is rounded
// and saturated to 32 bits.
// The history sits in a chain of WINDOW-1 cells that shifts one cell per
// cycle while running, past a single multiplier: an item passes through the
// multiply steps (S_RUN), a step that folds in the last product (S_DRAIN)
// and a step that rounds the sum and loads it into the output register
// (S_FIN). The next item is taken in the cycle the result is loaded; an
// item is not accepted while the previous one is still in progress.
// The result waits in an output register while i_out_stall is high; a
// finished result waits in S_FIN, with o_in_stall high, until that register is free.
// Reset (synchronous, active low) clears the history to zero, drops any
// item in flight and any pending result; o_in_stall is high during reset.
module least_squares_line_predictor
    import lslp_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_prediction
);

    localparam int HIST   = WINDOW - 1;
    localparam int STEP_W = $clog2(WINDOW);

    logic signed [WEIGHT_W-1:0] w_tab [WINDOW];
    logic signed [SAMPLE_W-1:0] hist  [HIST];
    logic signed [SAMPLE_W-1:0] chain_in [HIST];

    t_state                     r_state;
    t_state                     n_state;
    logic [STEP_W-1:0]          r_step;
    logic [STEP_W-1:0]          n_step;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic signed [SAMPLE_W-1:0] r_pred;

    logic                       last_step;
    logic                       out_free;
    logic                       in_acc;
    logic                       load_out;
    logic signed [SAMPLE_W-1:0] tail_in;
    logic signed [SAMPLE_W-1:0] operand;
    logic signed [SAMPLE_W-1:0] mac_result;
    t_mac_ctl                   mac_ctl;

    // Tap weights: w_i = 2*(3i - N + 1) / (N(N-1)) in Q.20, ties away from zero.
    for (genvar g = 0; g < WINDOW; g++) begin : g_wgt
        localparam longint Num = longint'(2 * (3 * g - WINDOW + 1)) *
                                 (longint'(1) <<< FRAC_W);
        localparam longint Den = longint'(WINDOW * (WINDOW - 1));
        localparam longint Wgt = (Num >= 0) ? (Num + Den / 2) / Den
                                            : -((-Num + Den / 2) / Den);
        assign w_tab[g] = WEIGHT_W'(Wgt);
    end

    assign last_step = (r_step == STEP_W'(WINDOW - 1));

    // Head cell feeds the multiplier and wraps to the tail; on the last tap
    // the new sample enters instead and the oldest one drops out.
    assign tail_in = last_step ? r_sample : hist[0];
    assign operand = last_step ? r_sample : hist[0];

    for (genvar g = 0; g < HIST; g++) begin : g_chain
        if (g == HIST - 1) begin : g_tail
            assign chain_in[g] = tail_in;
        end else begin : g_mid
            assign chain_in[g] = hist[g + 1];
        end
        lslp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (r_state == S_RUN),
            .i_d     (chain_in[g]),
            .o_q     (hist[g])
        );
    end

    assign mac_ctl = '{mul_en: (r_state == S_RUN), first: (r_step == '0)};

    lslp_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_operand (operand),
        .i_weight  (w_tab[r_step]),
        .o_result  (mac_result)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_out   = (r_state == S_FIN) && out_free;
    assign o_in_stall = !i_rst_n || !((r_state == S_IDLE) || load_out);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                if (last_step) begin
                    n_state = S_DRAIN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = in_acc ? S_RUN : S_IDLE;
                    n_step      = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample;
        end
        if (load_out) begin
            r_pred <= mac_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_prediction = r_pred;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_RUN) && (r_step == '0))
        else $error("accepted item did not start at the first tap");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> o_out_valid)
        else $error("finished result not presented");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_W'(WINDOW - 1))
        else $error("tap counter out of range");

    a_drain_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> $past(r_state == S_RUN && last_step))
        else $error("drain entered without finishing the taps");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN || r_state == S_DRAIN) |-> o_in_stall)
        else $error("input open while taps are in progress");

endmodule
